[src/ppbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppbd_pkg
// Shared types and codes for the pending packet buffer.
// ----------------------------------------------------------------------------
package ppbd_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SEND  = 3'd1,
        OP_DROP  = 3'd2,
        OP_GET   = 3'd3,
        OP_FLUSH = 3'd4
    } op_t;

    localparam logic [2:0] RS_ADDED     = 3'd0;
    localparam logic [2:0] RS_FULL      = 3'd1;
    localparam logic [2:0] RS_SENT      = 3'd2;
    localparam logic [2:0] RS_FLUSHED   = 3'd3;
    localparam logic [2:0] RS_FOUND     = 3'd4;
    localparam logic [2:0] RS_NOT_FOUND = 3'd5;
    localparam logic [2:0] RS_REMOVED   = 3'd6;

    // command queue between front and back
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] dest;
    } entry_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] handle;
        logic [31:0] dest;
    } cmd_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_COUNT,
        BS_EMIT,
        BS_DROP,
        BS_GET,
        BS_FLUSH
    } back_state_t;

endpackage

[src/ppbd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppbd_front
// Accepts commands, discards unknown codes and queues the rest.
// ----------------------------------------------------------------------------
module ppbd_front
    import ppbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  func,
    input  logic [15:0] packet_handle,
    input  logic [31:0] dest_addr,
    output logic        busy,
    output logic        q_valid,
    output cmd_t        q_cmd,
    input  logic        q_pop
);

    cmd_t       q_reg [Q_DEPTH];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       known;
    op_t        op;
    logic       push;

    always_comb
    begin
        known = 1'b1;
        op    = OP_ADD;
        case (func)
            OP_ADD:   op = OP_ADD;
            OP_SEND:  op = OP_SEND;
            OP_DROP:  op = OP_DROP;
            OP_GET:   op = OP_GET;
            OP_FLUSH: op = OP_FLUSH;
            default:  known = 1'b0;
        endcase
    end

    assign busy    = (cnt_reg == 2'(Q_DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = q_reg[rp_reg];
    assign push    = start && !busy && known;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= '{op: op, handle: packet_handle, dest: dest_addr};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

[src/ppbd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppbd_back
// Executes queued commands against the slot memory; scans one slot a cycle.
// ----------------------------------------------------------------------------
module ppbd_back
    import ppbd_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] out_handle,
    output logic [31:0] out_dest,
    output logic [4:0]  removed_count,
    output logic [4:0]  occupancy,
    output logic        last_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    back_state_t   state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] wr_idx_reg, wr_idx_next;
    logic [CW-1:0] hits_reg, hits_next;
    logic [CW-1:0] k_reg, k_next;
    logic          pend_reg, pend_next;

    logic          done_reg, done_next;
    logic [2:0]    status_reg, status_next;
    logic [15:0]   handle_reg, handle_next;
    logic [31:0]   dest_reg, dest_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic          last_reg, last_next;

    logic          rd_en;
    logic          we;
    logic [AW-1:0] wa;
    entry_t        wd;
    logic          match;
    logic          scan_more;
    logic          scan_end;
    logic          fin;

    assign match     = pend_reg && (rd_data_reg.dest == cmd_reg.dest);
    assign scan_more = (rd_idx_reg < count_reg);
    assign scan_end  = !scan_more && !pend_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        hits_next   = hits_reg;
        k_next      = k_reg;
        pend_next   = 1'b0;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        we          = 1'b0;
        wa          = wr_idx_reg[AW-1:0];
        wd          = rd_data_reg;
        done_next   = 1'b0;
        status_next = RS_REMOVED;
        handle_next = '0;
        dest_next   = '0;
        rem_next    = '0;
        occ_next    = count_reg;
        last_next   = 1'b1;
        fin         = 1'b0;

        // every scan state walks the live slots through the read port
        if (state_reg != BS_IDLE && scan_more)
        begin
            rd_en       = 1'b1;
            rd_idx_next = rd_idx_reg + CW'(1);
            pend_next   = 1'b1;
        end

        case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cmd_next    = q_cmd;
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    hits_next   = '0;
                    k_next      = '0;
                    case (q_cmd.op)
                        OP_ADD:
                        begin
                            done_next = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = RS_FULL;
                            end
                            else
                            begin
                                we          = 1'b1;
                                wa          = count_reg[AW-1:0];
                                wd          = '{handle: q_cmd.handle, dest: q_cmd.dest};
                                count_next  = count_reg + CW'(1);
                                status_next = RS_ADDED;
                                occ_next    = count_reg + CW'(1);
                            end
                        end
                        OP_SEND:  state_next = BS_COUNT;
                        OP_DROP:  state_next = BS_DROP;
                        OP_GET:   state_next = BS_GET;
                        OP_FLUSH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = BS_FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_COUNT:
            begin
                if (match)
                begin
                    hits_next = hits_reg + CW'(1);
                end
                if (scan_end)
                begin
                    if (hits_reg == '0)
                    begin
                        done_next  = 1'b1;
                        state_next = BS_IDLE;
                    end
                    else
                    begin
                        // second pass: emit matches, compact the rest in place
                        state_next  = BS_EMIT;
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                        rd_en       = 1'b0;
                    end
                end
            end
            BS_EMIT:
            begin
                if (match)
                begin
                    done_next   = 1'b1;
                    status_next = RS_SENT;
                    handle_next = rd_data_reg.handle;
                    dest_next   = rd_data_reg.dest;
                    occ_next    = count_reg - k_reg - CW'(1);
                    last_next   = (k_reg + CW'(1) == hits_reg);
                    rem_next    = last_next ? hits_reg : '0;
                    k_next      = k_reg + CW'(1);
                end
                else if (pend_reg)
                begin
                    we          = 1'b1;
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
                if (scan_end)
                begin
                    count_next = wr_idx_reg;
                    state_next = BS_IDLE;
                end
            end
            BS_DROP:
            begin
                if (pend_reg && !match)
                begin
                    we          = 1'b1;
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
                if (scan_end)
                begin
                    done_next  = 1'b1;
                    rem_next   = count_reg - wr_idx_reg;
                    occ_next   = wr_idx_reg;
                    count_next = wr_idx_reg;
                    state_next = BS_IDLE;
                end
            end
            BS_GET:
            begin
                if (match)
                begin
                    fin         = 1'b1;
                    status_next = RS_FOUND;
                    handle_next = rd_data_reg.handle;
                    dest_next   = rd_data_reg.dest;
                end
                else if (scan_end)
                begin
                    fin         = 1'b1;
                    status_next = RS_NOT_FOUND;
                end
                if (fin)
                begin
                    done_next  = 1'b1;
                    pend_next  = 1'b0;
                    state_next = BS_IDLE;
                end
            end
            BS_FLUSH:
            begin
                if (pend_reg)
                begin
                    done_next   = 1'b1;
                    status_next = RS_FLUSHED;
                    handle_next = rd_data_reg.handle;
                    dest_next   = rd_data_reg.dest;
                    occ_next    = count_reg - k_reg - CW'(1);
                    last_next   = (k_reg + CW'(1) == count_reg);
                    rem_next    = last_next ? count_reg : '0;
                    k_next      = k_reg + CW'(1);
                end
                if (scan_end)
                begin
                    count_next = '0;
                    state_next = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rd_idx_reg <= rd_idx_next;
        wr_idx_reg <= wr_idx_next;
        hits_reg   <= hits_next;
        k_reg      <= k_next;
        status_reg <= status_next;
        handle_reg <= handle_next;
        dest_reg   <= dest_next;
        rem_reg    <= rem_next;
        occ_reg    <= occ_next;
        last_reg   <= last_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign out_handle    = handle_reg;
    assign out_dest      = dest_reg;
    assign removed_count = 5'(rem_reg);
    assign occupancy     = 5'(occ_reg);
    assign last_result   = last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(rd_en))
        else $error("read data marked valid without a read");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (we && state_reg != BS_IDLE) |-> (wr_idx_reg < rd_idx_reg))
        else $error("compaction write overtakes the read pointer");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_EMIT) |-> (k_reg <= hits_reg))
        else $error("more sends than counted matches");
`endif

endmodule

[src/pending_packet_buffer_by_destination.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_packet_buffer_by_destination
// Insertion-ordered buffer of packets waiting for a route, keyed by dest.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// command   in         start && !busy      func, packet_handle, dest_addr
// result    out        done (one cycle)    status, out_handle, out_dest,
//                                          removed_count, occupancy, last_result
//
// Commands pass a two-entry queue, then execute one at a time.
// Add and a flush of an empty buffer finish in the idle state; get (which stops at
// the first match), drop and flush scan the slots; send scans twice (count pass, then
// emit and compact pass), once when nothing matches. On an empty buffer get, drop and
// send still pass through their scan state. The slot memory has a single read port.
// Reset empties the buffer at once; slot contents are not cleared.
// busy rises only when the queue is full; results cannot be stalled.
// ----------------------------------------------------------------------------
module pending_packet_buffer_by_destination
    import ppbd_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [15:0] packet_handle,
    input  logic [31:0] dest_addr,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] out_handle,
    output logic [31:0] out_dest,
    output logic [4:0]  removed_count,
    output logic [4:0]  occupancy,
    output logic        last_result
);

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    ppbd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .packet_handle (packet_handle),
        .dest_addr     (dest_addr),
        .busy          (busy),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    ppbd_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .done          (done),
        .status        (status),
        .out_handle    (out_handle),
        .out_dest      (out_dest),
        .removed_count (removed_count),
        .occupancy     (occupancy),
        .last_result   (last_result)
    );

endmodule
